// ===== src/uart_register_block_fifo_core_defines.svh =====
// Assertion macros used by the checker file of the UART register block.
`ifndef UART_REGISTER_BLOCK_FIFO_CORE_DEFINES_SVH
`define UART_REGISTER_BLOCK_FIFO_CORE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define URBF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("urbf assertion failed");

// Property checked on every clock edge, reset included.
`define URBF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("urbf assertion failed");

`endif

// ===== src/urbf_pkg.sv =====
package urbf_pkg;

   localparam int FIFO_DEPTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int OP_W   = 2;
   localparam int REG_W  = 5;
   localparam int DATA_W = 16;
   localparam int BYTE_W = 8;
   localparam int MASK_W = 11;
   localparam int FBRD_W = 6;
   localparam int LCR_W  = 8;

   localparam logic [OP_W-1:0] OP_BUS_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_BUS_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_LINE_BYTE = 2'd2;
   localparam logic [OP_W-1:0] OP_TX_SLOT   = 2'd3;

   localparam logic [REG_W-1:0] REG_DR   = 5'd0;
   localparam logic [REG_W-1:0] REG_RSR  = 5'd1;
   localparam logic [REG_W-1:0] REG_FR   = 5'd6;
   localparam logic [REG_W-1:0] REG_IBRD = 5'd9;
   localparam logic [REG_W-1:0] REG_FBRD = 5'd10;
   localparam logic [REG_W-1:0] REG_LCR  = 5'd11;
   localparam logic [REG_W-1:0] REG_CR   = 5'd12;
   localparam logic [REG_W-1:0] REG_IMSC = 5'd14;
   localparam logic [REG_W-1:0] REG_RIS  = 5'd15;
   localparam logic [REG_W-1:0] REG_MIS  = 5'd16;
   localparam logic [REG_W-1:0] REG_ICR  = 5'd17;

   localparam logic [DATA_W-1:0] CR_RESET = 16'h0300;

   localparam int LCR_FEN_BIT = 4;
   localparam int CR_EN_BIT   = 0;
   localparam int CR_TXE_BIT  = 8;
   localparam int CR_RXE_BIT  = 9;
   localparam int RIS_RX_BIT  = 4;
   localparam int RIS_TX_BIT  = 5;
   localparam int RIS_OE_BIT  = 10;
   localparam int RSR_OE_BIT  = 3;

   typedef enum logic [2:0] {
      CMD_RD_DR,
      CMD_RD_REG,
      CMD_WR_DR,
      CMD_WR_REG,
      CMD_RX_BYTE,
      CMD_TX_SLOT
   } urbf_cmd_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [REG_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
      logic [BYTE_W-1:0] line_byte;
   } urbf_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              irq;
   } urbf_rsp_type;

   typedef struct packed {
      urbf_cmd_kind_type kind;
      logic [REG_W-1:0]  reg_index;
      logic [DATA_W-1:0] data;
   } urbf_cmd_type;

endpackage

// ===== src/urbf_front.sv =====
module urbf_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  urbf_pkg::urbf_req_type req_payload,
   output logic                  push_valid,
   input  logic                  push_ready,
   output urbf_pkg::urbf_cmd_type push_cmd
);

   always_comb begin
      push_valid         = req_valid;
      req_ready          = push_ready;
      push_cmd.reg_index = req_payload.reg_index;
      push_cmd.data      = req_payload.write_data;
      push_cmd.kind      = urbf_pkg::CMD_TX_SLOT;
      unique case (req_payload.operation)
         urbf_pkg::OP_BUS_READ: begin
            push_cmd.kind = (req_payload.reg_index == urbf_pkg::REG_DR) ?
                            urbf_pkg::CMD_RD_DR : urbf_pkg::CMD_RD_REG;
         end
         urbf_pkg::OP_BUS_WRITE: begin
            push_cmd.kind = (req_payload.reg_index == urbf_pkg::REG_DR) ?
                            urbf_pkg::CMD_WR_DR : urbf_pkg::CMD_WR_REG;
         end
         urbf_pkg::OP_LINE_BYTE: begin
            push_cmd.kind = urbf_pkg::CMD_RX_BYTE;
            // The received byte travels in the low half of the data field.
            push_cmd.data = {{(urbf_pkg::DATA_W - urbf_pkg::BYTE_W){1'b0}},
                             req_payload.line_byte};
         end
         urbf_pkg::OP_TX_SLOT: begin
            push_cmd.kind = urbf_pkg::CMD_TX_SLOT;
         end
         default: begin
            push_cmd.kind = urbf_pkg::CMD_TX_SLOT;
         end
      endcase
   end

endmodule

// ===== src/urbf_queue.sv =====
module urbf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  urbf_pkg::urbf_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output urbf_pkg::urbf_cmd_type pop_cmd
);

   localparam int QPW = $clog2(urbf_pkg::QUEUE_DEPTH);
   localparam int QCW = $clog2(urbf_pkg::QUEUE_DEPTH + 1);
   localparam logic [QPW-1:0] LAST_PTR = QPW'(urbf_pkg::QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] FULL_CNT = QCW'(urbf_pkg::QUEUE_DEPTH);

   urbf_pkg::urbf_cmd_type entry_ff [urbf_pkg::QUEUE_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] count_ff, count_in;
   logic           do_push, do_pop;

   always_comb begin
      push_ready = (count_ff != FULL_CNT);
      pop_valid  = (count_ff != '0);
      pop_cmd    = entry_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/urbf_back.sv =====
module urbf_back #(
   parameter int FIFO_DEPTH = urbf_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  urbf_pkg::urbf_cmd_type cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output urbf_pkg::urbf_rsp_type rsp_payload
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);
   localparam logic [CW-1:0] ONE_CNT  = CW'(1);

   localparam int DW = urbf_pkg::DATA_W;
   localparam int BW = urbf_pkg::BYTE_W;
   localparam int MW = urbf_pkg::MASK_W;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   logic [BW-1:0] tx_mem [FIFO_DEPTH];
   logic [BW-1:0] rx_mem [FIFO_DEPTH];

   logic [PW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [PW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [CW-1:0] tx_count_ff, tx_count_in, rx_count_ff, rx_count_in;

   logic [DW-1:0]                  ctrl_ff, ctrl_in;
   logic [urbf_pkg::LCR_W-1:0]     lcr_ff, lcr_in;
   logic [DW-1:0]                  ibrd_ff, ibrd_in;
   logic [urbf_pkg::FBRD_W-1:0]    fbrd_ff, fbrd_in;
   logic [MW-1:0]                  imsc_ff, imsc_in;
   logic [MW-1:0]                  ris_ff, ris_in;
   logic                           ovr_ff, ovr_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rd_ff, rd_in;
   logic          pop_rx_ff, pop_tx_ff;
   logic          irq_ff, irq_in;
   logic [BW-1:0] rx_q_ff, tx_q_ff;

   logic          exec;
   logic          rx_push, rx_pop, tx_push, tx_pop;
   logic [CW-1:0] depth;
   logic          rx_room, tx_room, rx_enabled, tx_enabled;
   logic [DW-1:0] reg_value;
   logic [MW-1:0] mis;

   always_comb begin
      cmd_ready  = !rsp_valid_ff || rsp_ready;
      exec       = cmd_valid && cmd_ready;
      depth      = lcr_ff[urbf_pkg::LCR_FEN_BIT] ? FULL_CNT : ONE_CNT;
      rx_room    = rx_count_ff < depth;
      tx_room    = tx_count_ff < depth;
      rx_enabled = ctrl_ff[urbf_pkg::CR_EN_BIT] && ctrl_ff[urbf_pkg::CR_RXE_BIT];
      tx_enabled = ctrl_ff[urbf_pkg::CR_EN_BIT] && ctrl_ff[urbf_pkg::CR_TXE_BIT];
      mis        = ris_ff & imsc_ff;

      reg_value = '0;
      unique case (cmd.reg_index)
         urbf_pkg::REG_RSR: begin
            reg_value[urbf_pkg::RSR_OE_BIT] = ovr_ff;
         end
         urbf_pkg::REG_FR: begin
            reg_value[7] = (tx_count_ff == '0);
            reg_value[6] = !rx_room;
            reg_value[5] = !tx_room;
            reg_value[4] = (rx_count_ff == '0);
         end
         urbf_pkg::REG_IBRD: reg_value = ibrd_ff;
         urbf_pkg::REG_FBRD: reg_value = {{(DW - urbf_pkg::FBRD_W){1'b0}}, fbrd_ff};
         urbf_pkg::REG_LCR:  reg_value = {{(DW - urbf_pkg::LCR_W){1'b0}}, lcr_ff};
         urbf_pkg::REG_CR:   reg_value = ctrl_ff;
         urbf_pkg::REG_IMSC: reg_value = {{(DW - MW){1'b0}}, imsc_ff};
         urbf_pkg::REG_RIS:  reg_value = {{(DW - MW){1'b0}}, ris_ff};
         urbf_pkg::REG_MIS:  reg_value = {{(DW - MW){1'b0}}, mis};
         default:            reg_value = '0;
      endcase

      ctrl_in = ctrl_ff;
      lcr_in  = lcr_ff;
      ibrd_in = ibrd_ff;
      fbrd_in = fbrd_ff;
      imsc_in = imsc_ff;
      ris_in  = ris_ff;
      ovr_in  = ovr_ff;
      rd_in   = '0;
      rx_push = 1'b0;
      rx_pop  = 1'b0;
      tx_push = 1'b0;
      tx_pop  = 1'b0;

      if (exec) begin
         unique case (cmd.kind)
            urbf_pkg::CMD_RD_DR: begin
               rx_pop = (rx_count_ff != '0);
            end
            urbf_pkg::CMD_RD_REG: begin
               rd_in = reg_value;
            end
            urbf_pkg::CMD_WR_DR: begin
               tx_push = tx_room;
            end
            urbf_pkg::CMD_WR_REG: begin
               unique case (cmd.reg_index)
                  urbf_pkg::REG_RSR:  ovr_in  = 1'b0;
                  urbf_pkg::REG_IBRD: ibrd_in = cmd.data;
                  urbf_pkg::REG_FBRD: fbrd_in = cmd.data[urbf_pkg::FBRD_W-1:0];
                  urbf_pkg::REG_LCR:  lcr_in  = cmd.data[urbf_pkg::LCR_W-1:0];
                  urbf_pkg::REG_CR:   ctrl_in = cmd.data;
                  urbf_pkg::REG_IMSC: imsc_in = cmd.data[MW-1:0];
                  urbf_pkg::REG_ICR:  ris_in  = ris_ff & ~cmd.data[MW-1:0];
                  default: ;
               endcase
            end
            urbf_pkg::CMD_RX_BYTE: begin
               if (rx_enabled) begin
                  if (rx_room) begin
                     rx_push = 1'b1;
                     ris_in[urbf_pkg::RIS_RX_BIT] = 1'b1;
                  end else begin
                     ovr_in = 1'b1;
                     ris_in[urbf_pkg::RIS_OE_BIT] = 1'b1;
                  end
               end
            end
            urbf_pkg::CMD_TX_SLOT: begin
               if (tx_enabled && (tx_count_ff != '0)) begin
                  tx_pop = 1'b1;
                  // The transmit interrupt fires when the last byte leaves.
                  if (tx_count_ff == ONE_CNT) begin
                     ris_in[urbf_pkg::RIS_TX_BIT] = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      rx_head_in  = rx_pop  ? ptr_next(rx_head_ff) : rx_head_ff;
      rx_tail_in  = rx_push ? ptr_next(rx_tail_ff) : rx_tail_ff;
      tx_head_in  = tx_pop  ? ptr_next(tx_head_ff) : tx_head_ff;
      tx_tail_in  = tx_push ? ptr_next(tx_tail_ff) : tx_tail_ff;
      rx_count_in = rx_push ? rx_count_ff + ONE_CNT :
                    rx_pop  ? rx_count_ff - ONE_CNT : rx_count_ff;
      tx_count_in = tx_push ? tx_count_ff + ONE_CNT :
                    tx_pop  ? tx_count_ff - ONE_CNT : tx_count_ff;

      irq_in       = |(ris_in & imsc_in);
      rsp_valid_in = exec ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_count_ff  <= '0;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_count_ff  <= '0;
         ctrl_ff      <= urbf_pkg::CR_RESET;
         lcr_ff       <= '0;
         ibrd_ff      <= '0;
         fbrd_ff      <= '0;
         imsc_ff      <= '0;
         ris_ff       <= '0;
         ovr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_count_ff  <= tx_count_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_count_ff  <= rx_count_in;
         ctrl_ff      <= ctrl_in;
         lcr_ff       <= lcr_in;
         ibrd_ff      <= ibrd_in;
         fbrd_ff      <= fbrd_in;
         imsc_ff      <= imsc_in;
         ris_ff       <= ris_in;
         ovr_ff       <= ovr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload is only loaded when a request is carried out, so it holds
   // steady while the consumer stalls.
   always_ff @(posedge clock) begin
      if (exec) begin
         rd_ff     <= rd_in;
         pop_rx_ff <= rx_pop;
         pop_tx_ff <= tx_pop;
         irq_ff    <= irq_in;
      end
   end

   // A push and a pop never share a cycle, so a pop never reads the slot
   // being written.
   always_ff @(posedge clock) begin
      if (rx_push) begin
         rx_mem[rx_tail_ff] <= cmd.data[BW-1:0];
      end
      if (rx_pop) begin
         rx_q_ff <= rx_mem[rx_head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_push) begin
         tx_mem[tx_tail_ff] <= cmd.data[BW-1:0];
      end
      if (tx_pop) begin
         tx_q_ff <= tx_mem[tx_head_ff];
      end
   end

   always_comb begin
      rsp_valid             = rsp_valid_ff;
      rsp_payload.read_data = pop_rx_ff ? {{(DW - BW){1'b0}}, rx_q_ff} : rd_ff;
      rsp_payload.tx_valid  = pop_tx_ff;
      rsp_payload.tx_byte   = pop_tx_ff ? tx_q_ff : '0;
      rsp_payload.irq       = irq_ff;
   end

endmodule

// ===== src/uart_register_block_fifo_core.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | urbf_req_type: operation, index, data, byte
// rsp     | out       | rsp_valid/rsp_ready | urbf_rsp_type: read data, tx byte, irq
//
// One request per cycle is taken and one result per cycle is given while rsp_ready stays high.
// A request's result passes through the two-entry command queue and then the
// execute unit's output register before it can be taken.
// The execute unit updates all state once per cycle, which sets that rate.
// Reset is synchronous and clears pointers, counts and registers; the FIFO
// stores are not cleared. A stalled result holds, the queue absorbs two
// further requests, and then req_ready falls.
module uart_register_block_fifo_core #(
   parameter int FIFO_DEPTH = urbf_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  urbf_pkg::urbf_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output urbf_pkg::urbf_rsp_type rsp_payload
);

   logic                   push_valid, push_ready;
   urbf_pkg::urbf_cmd_type push_cmd;
   logic                   pop_valid, pop_ready;
   urbf_pkg::urbf_cmd_type pop_cmd;

   urbf_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   urbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   urbf_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd         (pop_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== src/urbf_checker.sv =====
`include "uart_register_block_fifo_core_defines.svh"

module urbf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input urbf_pkg::urbf_req_type req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input urbf_pkg::urbf_rsp_type rsp_payload
);

   `URBF_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)

   `URBF_ASSERT_ALWAYS(a_ready_after_reset, clock, reset |=> req_ready)

   `URBF_ASSERT(a_tx_byte_zero, clock, reset,
      (rsp_valid && !rsp_payload.tx_valid) |-> (rsp_payload.tx_byte == '0))

   `URBF_ASSERT(a_send_has_no_read, clock, reset,
      (rsp_valid && rsp_payload.tx_valid) |-> (rsp_payload.read_data == '0))

   `URBF_ASSERT(a_rsp_holds, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))

endmodule

bind uart_register_block_fifo_core urbf_checker u_checker (.*);

// ===== dv/uart_register_block_fifo_core_test.sv =====
module uart_register_block_fifo_core_test;
   import urbf_pkg::*;

   localparam int DEPTH       = FIFO_DEPTH_DEFAULT;
   localparam int STALL_LIMIT = 2000;
   localparam int MAX_SHOWN   = 10;

   localparam int FR_TXFE_BIT = 7;
   localparam int FR_RXFF_BIT = 6;
   localparam int FR_TXFF_BIT = 5;
   localparam int FR_RXFE_BIT = 4;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   urbf_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   urbf_rsp_type rsp_payload;

   // When set, neither side inserts gaps or stalls.
   bit no_gaps = 1'b0;

   urbf_rsp_type rsp_predicted_q[$];
   int unsigned  error_count = 0;
   int unsigned  quiet_cycles = 0;

   // Shadow copy of the register block.
   logic [BYTE_W-1:0] tx_mem [DEPTH];
   logic [BYTE_W-1:0] rx_mem [DEPTH];
   int unsigned       tx_head = 0;
   int unsigned       tx_level = 0;
   int unsigned       rx_head = 0;
   int unsigned       rx_level = 0;
   logic [DATA_W-1:0] cr_q = CR_RESET;
   logic [DATA_W-1:0] ibrd_q = '0;
   logic [FBRD_W-1:0] fbrd_q = '0;
   logic [LCR_W-1:0]  lcr_q = '0;
   logic [MASK_W-1:0] imsc_q = '0;
   logic [MASK_W-1:0] ris_q = '0;
   logic              oe_flag = 1'b0;

   uart_register_block_fifo_core #(
      .FIFO_DEPTH(DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one request to the shadow state and returns the result it should give.
   function automatic urbf_rsp_type uart_regs_step(input urbf_req_type r);
      urbf_rsp_type o;
      int unsigned  room;
      o = '0;
      room = lcr_q[LCR_FEN_BIT] ? DEPTH : 1;
      case (r.operation)
         OP_BUS_READ: begin
            case (r.reg_index)
               REG_DR: begin
                  if (rx_level != 0) begin
                     o.read_data[BYTE_W-1:0] = rx_mem[rx_head];
                     rx_head = (rx_head + 1) % DEPTH;
                     rx_level--;
                  end
               end
               REG_RSR: o.read_data[RSR_OE_BIT] = oe_flag;
               REG_FR: begin
                  o.read_data[FR_TXFE_BIT] = (tx_level == 0);
                  o.read_data[FR_RXFF_BIT] = (rx_level >= room);
                  o.read_data[FR_TXFF_BIT] = (tx_level >= room);
                  o.read_data[FR_RXFE_BIT] = (rx_level == 0);
               end
               REG_IBRD: o.read_data = ibrd_q;
               REG_FBRD: o.read_data[FBRD_W-1:0] = fbrd_q;
               REG_LCR:  o.read_data[LCR_W-1:0] = lcr_q;
               REG_CR:   o.read_data = cr_q;
               REG_IMSC: o.read_data[MASK_W-1:0] = imsc_q;
               REG_RIS:  o.read_data[MASK_W-1:0] = ris_q;
               REG_MIS:  o.read_data[MASK_W-1:0] = ris_q & imsc_q;
               default: ;
            endcase
         end
         OP_BUS_WRITE: begin
            case (r.reg_index)
               REG_DR: begin
                  if (tx_level < room) begin
                     tx_mem[(tx_head + tx_level) % DEPTH] = r.write_data[BYTE_W-1:0];
                     tx_level++;
                  end
               end
               REG_RSR:  oe_flag = 1'b0;
               REG_IBRD: ibrd_q = r.write_data;
               REG_FBRD: fbrd_q = r.write_data[FBRD_W-1:0];
               REG_LCR:  lcr_q = r.write_data[LCR_W-1:0];
               REG_CR:   cr_q = r.write_data;
               REG_IMSC: imsc_q = r.write_data[MASK_W-1:0];
               REG_ICR:  ris_q = ris_q & ~r.write_data[MASK_W-1:0];
               default: ;
            endcase
         end
         OP_LINE_BYTE: begin
            if (cr_q[CR_EN_BIT] && cr_q[CR_RXE_BIT]) begin
               if (rx_level < room) begin
                  rx_mem[(rx_head + rx_level) % DEPTH] = r.line_byte;
                  rx_level++;
                  ris_q[RIS_RX_BIT] = 1'b1;
               end else begin
                  oe_flag = 1'b1;
                  ris_q[RIS_OE_BIT] = 1'b1;
               end
            end
         end
         default: begin
            if (cr_q[CR_EN_BIT] && cr_q[CR_TXE_BIT] && tx_level != 0) begin
               o.tx_valid = 1'b1;
               o.tx_byte = tx_mem[tx_head];
               tx_head = (tx_head + 1) % DEPTH;
               tx_level--;
               if (tx_level == 0) ris_q[RIS_TX_BIT] = 1'b1;
            end
         end
      endcase
      o.irq = |(ris_q & imsc_q);
      return o;
   endfunction

   task automatic send_request(input urbf_req_type r);
      while (!no_gaps && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      rsp_predicted_q.push_back(uart_regs_step(r));
   endtask

   task automatic send_op(input logic [OP_W-1:0] op, input logic [REG_W-1:0] idx,
                          input logic [DATA_W-1:0] data, input logic [BYTE_W-1:0] lb);
      urbf_req_type r;
      r.operation  = op;
      r.reg_index  = idx;
      r.write_data = data;
      r.line_byte  = lb;
      send_request(r);
   endtask

   function automatic logic [REG_W-1:0] pick_register();
      case ($urandom_range(0, 11))
         0:  return REG_DR;
         1:  return REG_RSR;
         2:  return REG_FR;
         3:  return REG_IBRD;
         4:  return REG_FBRD;
         5:  return REG_LCR;
         6:  return REG_CR;
         7:  return REG_IMSC;
         8:  return REG_RIS;
         9:  return REG_MIS;
         10: return REG_ICR;
         default: return REG_W'($urandom_range(0, 31));
      endcase
   endfunction

   // Data-path traffic, leaning towards filling both FIFOs or towards draining them.
   function automatic urbf_req_type traffic_item(input bit fill);
      urbf_req_type r;
      int unsigned  pick;
      r.write_data = DATA_W'($urandom);
      r.line_byte  = BYTE_W'($urandom);
      r.reg_index  = REG_DR;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.operation = OP_BUS_READ;
         case ($urandom_range(0, 3))
            0: r.reg_index = REG_FR;
            1: r.reg_index = REG_RSR;
            2: r.reg_index = REG_RIS;
            default: r.reg_index = REG_MIS;
         endcase
      end else if (pick < 12) begin
         r.operation = OP_BUS_WRITE;
         r.reg_index = pick[0] ? REG_ICR : REG_RSR;
      end else if ((pick < 68) == fill) begin
         r.operation = $urandom_range(0, 1) ? OP_BUS_WRITE : OP_LINE_BYTE;
      end else begin
         r.operation = $urandom_range(0, 1) ? OP_BUS_READ : OP_TX_SLOT;
      end
      return r;
   endfunction

   task automatic enable_uart(input bit fifo_on);
      logic [DATA_W-1:0] lcr;
      lcr = DATA_W'($urandom);
      lcr[LCR_FEN_BIT] = fifo_on;
      send_op(OP_BUS_WRITE, REG_LCR, lcr, '0);
      send_op(OP_BUS_WRITE, REG_CR, DATA_W'($urandom | (1 << CR_EN_BIT) |
              (1 << CR_TXE_BIT) | (1 << CR_RXE_BIT)), '0);
      send_op(OP_BUS_WRITE, REG_IMSC, DATA_W'($urandom), '0);
   endtask

   task automatic test_special_cases();
      send_op(OP_BUS_READ,  REG_DR,   '0, '0);       // receive FIFO empty
      send_op(OP_TX_SLOT,   REG_DR,   '0, '0);       // transmitter not yet enabled
      send_op(OP_LINE_BYTE, REG_DR,   '0, 8'hFF);    // receiver not yet enabled
      send_op(OP_BUS_WRITE, REG_IMSC, 16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_CR,   16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_DR,   16'h00A5, '0);
      send_op(OP_BUS_WRITE, REG_DR,   16'hFF5A, '0); // dropped, depth is one
      send_op(OP_BUS_READ,  REG_FR,   '0, '0);
      send_op(OP_TX_SLOT,   REG_DR,   '0, '0);
      send_op(OP_TX_SLOT,   REG_DR,   '0, '0);       // nothing left to send
      send_op(OP_LINE_BYTE, REG_DR,   '0, 8'h00);
      send_op(OP_LINE_BYTE, REG_DR,   '0, 8'hFF);    // overrun
      send_op(OP_BUS_READ,  REG_RSR,  '0, '0);
      send_op(OP_BUS_READ,  REG_MIS,  '0, '0);
      send_op(OP_BUS_WRITE, REG_RSR,  '0, '0);
      send_op(OP_BUS_WRITE, REG_FR,   16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_RIS,  16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_MIS,  16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_ICR,  16'hFFFF, '0);
      send_op(OP_BUS_READ,  REG_ICR,  '0, '0);
      send_op(OP_BUS_WRITE, 5'd31,    16'hFFFF, '0);
      send_op(OP_BUS_READ,  5'd31,    '0, '0);
      send_op(OP_BUS_WRITE, REG_IBRD, 16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_FBRD, 16'hFFFF, '0);
      send_op(OP_BUS_WRITE, REG_LCR,  16'hFFFF, '0);
   endtask

   task automatic test_fifo_traffic();
      enable_uart(1'b1);
      no_gaps = 1'b1;
      for (int n = 0; n < 600; n++) begin
         if (n == 200) no_gaps = 1'b0;
         send_request(traffic_item((n / 32) % 2 == 0));
      end
   endtask

   task automatic test_single_entry_traffic();
      enable_uart(1'b0);
      for (int n = 0; n < 300; n++) send_request(traffic_item((n / 8) % 2 == 0));
   endtask

   // Arbitrary register accesses, including depth changes with data held in the FIFOs.
   task automatic test_register_noise();
      urbf_req_type r;
      for (int n = 0; n < 450; n++) begin
         if (n % 60 == 0) enable_uart($urandom_range(0, 1));
         r.operation  = OP_W'($urandom_range(0, 3));
         r.reg_index  = pick_register();
         r.write_data = DATA_W'($urandom);
         r.line_byte  = BYTE_W'($urandom);
         send_request(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= no_gaps || ($urandom_range(0, 99) >= 11);
   end

   task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
   endtask

   always @(posedge clock) begin
      urbf_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_predicted_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("result with no request outstanding: %h", rsp_payload);
         end else begin
            want = rsp_predicted_q.pop_front();
            if (rsp_payload.read_data !== want.read_data)
               note_mismatch("read_data", want.read_data, rsp_payload.read_data);
            if (rsp_payload.tx_valid !== want.tx_valid)
               note_mismatch("tx_valid", want.tx_valid, rsp_payload.tx_valid);
            if (rsp_payload.tx_byte !== want.tx_byte)
               note_mismatch("tx_byte", want.tx_byte, rsp_payload.tx_byte);
            if (rsp_payload.irq !== want.irq)
               note_mismatch("irq", want.irq, rsp_payload.irq);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_fifo_traffic();
      test_single_entry_traffic();
      test_register_noise();
      req_valid <= 1'b0;
      while (rsp_predicted_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0 && rsp_predicted_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
